@@ hw/rtl/nucleotide_two_bit_packer_top_assert.svh @@
// Assertion macros for the two-bit nucleotide packer top level.
// Expects clk and rst_n in scope at the point of use.
`ifndef NUCLEOTIDE_TWO_BIT_PACKER_TOP_ASSERT_SVH
`define NUCLEOTIDE_TWO_BIT_PACKER_TOP_ASSERT_SVH

// same-cycle implication
`define NUC2B_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nuc2b check failed");

// next-cycle implication
`define NUC2B_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nuc2b next-cycle check failed");

`endif

@@ hw/rtl/nuc2b_pkg.sv @@
// Shared types, constants and the base decoder for the nucleotide packer.
// No dependencies.
package nuc2b_pkg;

  localparam int WordBases = 32;
  localparam int CodeW     = 2;
  localparam int WordW     = WordBases * CodeW;
  localparam int FillW     = $clog2(WordBases);
  localparam int WnumW     = 27;
  localparam int LenOutW   = 32;

  localparam logic [CodeW-1:0] CodeA    = 2'd0;
  localparam logic [CodeW-1:0] CodeC    = 2'd1;
  localparam logic [CodeW-1:0] CodeG    = 2'd2;
  localparam logic [CodeW-1:0] CodeT    = 2'd3;
  localparam logic [CodeW-1:0] MaskBase = 2'b11;
  localparam logic [CodeW-1:0] MaskNone = 2'b00;

  typedef struct packed {
    logic             known;
    logic [CodeW-1:0] code;
  } base_code_t;

  typedef struct packed {
    logic               emit;
    logic [WordW-1:0]   seq_word;
    logic [WordW-1:0]   mask_word;
    logic [WnumW-1:0]   word_number;
    logic [LenOutW-1:0] sequence_length;
    logic               last_word;
  } pack_res_t;

  function automatic base_code_t decode_base(input logic [7:0] ch);
    base_code_t r;
    r.known = 1'b1;
    r.code  = CodeA;
    case (ch)
      "A", "a": r.code = CodeA;
      "C", "c": r.code = CodeC;
      "G", "g": r.code = CodeG;
      "T", "t": r.code = CodeT;
      default:  r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/nuc2b_pack.sv @@
// Packing state and datapath: shift words, fill, word index, base counter.
// Depends on nuc2b_pkg.
module nuc2b_pack
  import nuc2b_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] base_char,
  input  logic       end_of_sequence,
  output pack_res_t  res
);

  localparam int CntExtW = (LENGTH_BITS > LenOutW) ? LENGTH_BITS : LenOutW;

  logic [WordW-3:0]       seq_r, seq_nxt;
  logic [WordW-3:0]       mask_r, mask_nxt;
  logic [FillW-1:0]       fill_r, fill_nxt;
  logic [WnumW-1:0]       widx_r, widx_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;

  base_code_t             bc;
  logic [WordW-1:0]       seq_cat, mask_cat;
  logic [FillW-1:0]       pad;
  logic                   full;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [CntExtW-1:0]     cnt_ext;

  assign bc       = decode_base(base_char);
  assign seq_cat  = {seq_r, bc.known ? bc.code : MaskNone};
  assign mask_cat = {mask_r, bc.known ? MaskBase : MaskNone};
  assign full     = (fill_r == FillW'(WordBases - 1));
  // bases of padding after this one; zero for a full word
  assign pad      = FillW'(WordBases - 1) - fill_r;
  assign cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign cnt_ext  = CntExtW'(cnt_inc);

  always_comb begin
    res.emit            = full || end_of_sequence;
    res.seq_word        = seq_cat << {pad, 1'b0};
    res.mask_word       = mask_cat << {pad, 1'b0};
    res.word_number     = widx_r;
    res.sequence_length = cnt_ext[LenOutW-1:0];
    res.last_word       = end_of_sequence;
  end

  always_comb begin
    seq_nxt  = seq_r;
    mask_nxt = mask_r;
    fill_nxt = fill_r;
    widx_nxt = widx_r;
    cnt_nxt  = cnt_r;
    if (take) begin
      if (end_of_sequence) begin
        seq_nxt  = '0;
        mask_nxt = '0;
        fill_nxt = '0;
        widx_nxt = '0;
        cnt_nxt  = '0;
      end else if (full) begin
        seq_nxt  = '0;
        mask_nxt = '0;
        fill_nxt = '0;
        widx_nxt = (widx_r == '1) ? widx_r : widx_r + 1'b1;
        cnt_nxt  = cnt_inc;
      end else begin
        seq_nxt  = seq_cat[WordW-3:0];
        mask_nxt = mask_cat[WordW-3:0];
        fill_nxt = fill_r + 1'b1;
        cnt_nxt  = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      mask_r <= '0;
      fill_r <= '0;
      widx_r <= '0;
      cnt_r  <= '0;
    end else begin
      seq_r  <= seq_nxt;
      mask_r <= mask_nxt;
      fill_r <= fill_nxt;
      widx_r <= widx_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/nucleotide_two_bit_packer_top.sv @@
// Two-bit nucleotide packer: input register, packing datapath, result register.
// Depends on nuc2b_pkg, nuc2b_pack and nucleotide_two_bit_packer_top_assert.svh.
//
// One character request is taken per clock unless a request that would produce
// a result waits on an occupied, stalled result register. A request is held in
// the input register, passes through the packing datapath and, if it completes
// a 32-base word or ends a sequence, lands in the result register when taken.
// Characters that finish no word move on even while a result waits to be
// taken; only a request that produces a result waits for the result register
// to drain.
`include "nucleotide_two_bit_packer_top_assert.svh"

module nucleotide_two_bit_packer_top
  import nuc2b_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_base_char,
  input  logic               in_end_of_sequence,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WordW-1:0]   out_seq_word,
  output logic [WordW-1:0]   out_mask_word,
  output logic [WnumW-1:0]   out_word_number,
  output logic [LenOutW-1:0] out_sequence_length,
  output logic               out_last_word
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_char_r;
  logic       in_eos_r;
  logic       out_valid_r, out_valid_nxt;
  pack_res_t  out_r;
  pack_res_t  res;
  logic       out_free;
  logic       take;

  nuc2b_pack #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_pack (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (take),
    .base_char       (in_char_r),
    .end_of_sequence (in_eos_r),
    .res             (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign take     = in_valid_r && (out_free || !res.emit);
  assign in_stall = in_valid_r && !take;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (!in_valid_r || take) begin
      in_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (take && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_valid_r || take) begin
      in_char_r <= in_base_char;
      in_eos_r  <= in_end_of_sequence;
    end
    if (take && res.emit) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_seq_word        = out_r.seq_word;
  assign out_mask_word       = out_r.mask_word;
  assign out_word_number     = out_r.word_number;
  assign out_sequence_length = out_r.sequence_length;
  assign out_last_word       = out_r.last_word;

  `NUC2B_CHECK(a_no_overwrite, take && res.emit, out_free)
  `NUC2B_CHECK(a_stall_needs_item, in_stall, in_valid_r)
  `NUC2B_CHECK(a_seq_within_mask, out_valid_r, (out_seq_word & ~out_mask_word) == '0)
  `NUC2B_CHECK_NEXT(a_request_held, in_valid && !in_stall, in_valid_r)

endmodule

@@ bench/nucleotide_two_bit_packer_checker.sv @@
// Checker for the two-bit nucleotide packer: follows both request channels,
// predicts each packed word and compares it with what the block emits.
// Depends on nuc2b_pkg for widths, base codes and mask values.
`timescale 1ns / 1ps

module nucleotide_two_bit_packer_checker
  import nuc2b_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_base_char,
  input  logic               in_end_of_sequence,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [WordW-1:0]   out_seq_word,
  input  logic [WordW-1:0]   out_mask_word,
  input  logic [WnumW-1:0]   out_word_number,
  input  logic [LenOutW-1:0] out_sequence_length,
  input  logic               out_last_word,
  output int                 mismatch_count,
  output int                 words_pending
);

  typedef struct packed {
    logic [WordW-1:0]   seq_word;
    logic [WordW-1:0]   mask_word;
    logic [WnumW-1:0]   word_number;
    logic [LenOutW-1:0] sequence_length;
    logic               last_word;
  } packed_word_t;

  localparam logic [63:0]      LenCeiling     = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam logic [WnumW-1:0] WordPosCeiling = '1;

  packed_word_t     expected_words[$];
  logic [WordW-1:0] seq_acc    = '0;
  logic [WordW-1:0] mask_acc   = '0;
  logic [63:0]      bases_seen = '0;
  logic [WnumW-1:0] word_pos   = '0;
  int               word_fill  = 0;
  int               errors     = 0;

  function automatic base_code_t classify_base(input logic [7:0] ch);
    base_code_t b;
    b.known = 1'b1;
    b.code  = CodeA;
    case (ch)
      "A", "a": b.code = CodeA;
      "C", "c": b.code = CodeC;
      "G", "g": b.code = CodeG;
      "T", "t": b.code = CodeT;
      default:  b.known = 1'b0;
    endcase
    return b;
  endfunction

  task automatic absorb_char(input logic [7:0] ch, input logic eos);
    base_code_t   b;
    packed_word_t w;
    int           pad;
    b        = classify_base(ch);
    seq_acc  = {seq_acc[WordW-CodeW-1:0], b.code & {CodeW{b.known}}};
    mask_acc = {mask_acc[WordW-CodeW-1:0], b.known ? MaskBase : MaskNone};
    if (bases_seen < LenCeiling) bases_seen = bases_seen + 64'd1;
    word_fill++;
    if (word_fill == WordBases || eos) begin
      // partial word at sequence end is left-aligned
      pad               = (WordBases - word_fill) * CodeW;
      w.seq_word        = seq_acc << pad;
      w.mask_word       = mask_acc << pad;
      w.word_number     = word_pos;
      w.sequence_length = bases_seen[LenOutW-1:0];
      w.last_word       = eos;
      expected_words.push_back(w);
      seq_acc   = '0;
      mask_acc  = '0;
      word_fill = 0;
      if (eos) begin
        bases_seen = '0;
        word_pos   = '0;
      end else if (word_pos != WordPosCeiling) begin
        word_pos = word_pos + 1'b1;
      end
    end
  endtask

  task automatic check_word();
    packed_word_t got;
    packed_word_t want;
    got = {out_seq_word, out_mask_word, out_word_number, out_sequence_length, out_last_word};
    if (expected_words.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("checker: unexpected word seq=%h mask=%h num=%0d len=%0d last=%b",
                 got.seq_word, got.mask_word, got.word_number, got.sequence_length,
                 got.last_word);
    end else begin
      want = expected_words.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display({"checker: mismatch\n",
                    "  expected seq=%h mask=%h num=%0d len=%0d last=%b\n",
                    "  actual   seq=%h mask=%h num=%0d len=%0d last=%b"},
                   want.seq_word, want.mask_word, want.word_number,
                   want.sequence_length, want.last_word,
                   got.seq_word, got.mask_word, got.word_number,
                   got.sequence_length, got.last_word);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seq_acc    = '0;
      mask_acc   = '0;
      bases_seen = '0;
      word_pos   = '0;
      word_fill  = 0;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) absorb_char(in_base_char, in_end_of_sequence);
      if (out_valid && !out_stall) check_word();
    end
    mismatch_count <= errors;
    words_pending  <= expected_words.size();
  end

endmodule

@@ bench/nucleotide_two_bit_packer_top_tb.sv @@
// Top of the two-bit nucleotide packer bench: clock, reset, character requests
// and receiver stalls; the checker beside the block does the prediction.
// Depends on nuc2b_pkg, nucleotide_two_bit_packer_top and the checker module.
`timescale 1ns / 1ps

module nucleotide_two_bit_packer_top_tb
  import nuc2b_pkg::*;
();

  localparam int LenBits = 32;

  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic [7:0]         in_base_char       = 8'h00;
  logic               in_end_of_sequence = 1'b0;
  logic               out_stall          = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [WordW-1:0]   out_seq_word;
  logic [WordW-1:0]   out_mask_word;
  logic [WnumW-1:0]   out_word_number;
  logic [LenOutW-1:0] out_sequence_length;
  logic               out_last_word;

  int mismatch_count;
  int words_pending;
  int chars_sent      = 0;
  int stall_hold      = 0;
  bit sender_idles    = 1'b0;
  bit receiver_stalls = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nucleotide_two_bit_packer_top #(
    .LENGTH_BITS(LenBits)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_base_char       (in_base_char),
    .in_end_of_sequence (in_end_of_sequence),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_seq_word       (out_seq_word),
    .out_mask_word      (out_mask_word),
    .out_word_number    (out_word_number),
    .out_sequence_length(out_sequence_length),
    .out_last_word      (out_last_word)
  );

  nucleotide_two_bit_packer_checker #(
    .LENGTH_BITS(LenBits)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_base_char       (in_base_char),
    .in_end_of_sequence (in_end_of_sequence),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_seq_word       (out_seq_word),
    .out_mask_word      (out_mask_word),
    .out_word_number    (out_word_number),
    .out_sequence_length(out_sequence_length),
    .out_last_word      (out_last_word),
    .mismatch_count     (mismatch_count),
    .words_pending      (words_pending)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return "A";
      1: return "C";
      2: return "G";
      3: return "T";
      4: return "a";
      5: return "c";
      6: return "g";
      default: return "t";
    endcase
  endfunction

  function automatic int pick_len();
    case ($urandom_range(0, 9))
      0: return 32;
      1: return 64;
      2: return $urandom_range(30, 34);
      3: return $urandom_range(62, 66);
      4: return $urandom_range(1, 2);
      default: return $urandom_range(1, 120);
    endcase
  endfunction

  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= receiver_stalls && ($urandom_range(0, 2) == 0);
      stall_hold <= idle_len();
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic eos);
    int gap;
    @(negedge clk);
    in_valid           <= 1'b1;
    in_base_char       <= ch;
    in_end_of_sequence <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    gap = sender_idles ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid           <= 1'b0;
      in_base_char       <= 8'($urandom_range(0, 255));
      in_end_of_sequence <= 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_sequence(input int len);
    for (int i = 0; i < len; i++) send_char(pick_char(), i == len - 1);
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 99) < 85) send_sequence(pick_len());
      else send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  // hold off requests until every predicted word has been taken
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_char("A", 1'b0);
    send_char("C", 1'b0);
    send_char("G", 1'b0);
    send_char("T", 1'b0);
    send_char("a", 1'b0);
    send_char("c", 1'b0);
    send_char("g", 1'b0);
    send_char("t", 1'b0);
    send_char(8'hC1, 1'b0);
    send_char("x", 1'b0);
    send_char("N", 1'b1);
    send_char("T", 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char("a", 1'b1);
    wait_drained();

    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    random_traffic(600);
    wait_drained();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    random_traffic(300);
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    random_traffic(600);

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
